[rtl/core/kary_tree_inorder_walker_unit_defines.svh]
// Assertion macros shared by the k-ary tree walker RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef KARY_TREE_INORDER_WALKER_UNIT_DEFINES_SVH
`define KARY_TREE_INORDER_WALKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define KITW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("kitw assertion failed");
// Check a property on every rising edge, reset included.
`define KITW_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("kitw assertion failed");
`else
`define KITW_ASSERT(label, clk, rst, prop)
`define KITW_ASSERT_NORST(label, clk, prop)
`endif

`endif

[rtl/core/kitw_pkg.sv]
// Types, register codes and constants for the k-ary tree in-order walker.
// Depends on nothing; used by every module of the walker.
`default_nettype none

package kitw_pkg;

   localparam int STACK_DEPTH_DEF = 32;
   localparam int INDEX_WIDTH_DEF = 32;

   localparam int FIELD_WIDTH    = 32;
   localparam int FANOUT_WIDTH   = 16;
   localparam int NC_WIDTH       = 17;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [FANOUT_WIDTH-1:0] MIN_FANOUT   = 16'd2;
   localparam logic [FANOUT_WIDTH-1:0] FANOUT_RESET = 16'd2;

   // Request actions
   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_NEXT  = 1'b1;

   // Register word indexes
   localparam logic [0:0] REG_NODE_COUNT = 1'b0;
   localparam logic [0:0] REG_FANOUT     = 1'b1;

   typedef struct packed {
      logic                   action;
      logic [FIELD_WIDTH-1:0] root_index;
   } req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] node_index;
      logic                   exhausted;
   } rsp_type;

   // Number of children walked before the node: ceil(k/2).
   function automatic logic [NC_WIDTH-1:0] half_of(input logic [FANOUT_WIDTH-1:0] k);
      logic [NC_WIDTH-1:0] sum;
      sum = {1'b0, k} + NC_WIDTH'(1);
      return sum >> 1;
   endfunction

endpackage

`default_nettype wire

[rtl/core/kary_tree_inorder_walker_unit.sv]
// Top level of the k-ary heap tree in-order walker: CSRs, sequencer, frame stack.
// Depends on kitw_pkg, kitw_child_unit, kitw_frame_ram and the defines header.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   req     | in        | req_valid/req_ready  | kitw_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_ready  | kitw_pkg::rsp_type
//   csr     | in/out    | psel/penable, pready | paddr, pwdata, prdata
//
// A start beat is accepted in idle and yields no response. A next beat goes to
// evaluate; a child probe forms the product there, then adds and compares in
// compare; a pop refilling the top frame from the frame RAM passes through load
// (the last pop does not); a node or exhaustion goes out via the result state.
// Sync reset clears sequencer, stack level, response valid; sets CSR defaults.
// req_ready is high only in idle; a stalled response blocks the next hand-off.
`default_nettype none

`include "kary_tree_inorder_walker_unit_defines.svh"

module kary_tree_inorder_walker_unit #(
   parameter int STACK_DEPTH = kitw_pkg::STACK_DEPTH_DEF,
   parameter int INDEX_WIDTH = kitw_pkg::INDEX_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire kitw_pkg::req_type                   req_data,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output kitw_pkg::rsp_type                        rsp_data,
   // configuration port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [kitw_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [kitw_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic      [kitw_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                     pready
);

   localparam int LVL_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = $clog2(STACK_DEPTH);
   localparam int NC_W    = kitw_pkg::NC_WIDTH;
   localparam int FAN_W   = kitw_pkg::FANOUT_WIDTH;
   localparam int FRAME_W = INDEX_WIDTH + NC_W + 1;

   // Sequencer codes
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EVAL   = 3'd1;
   localparam logic [2:0] ST_CMP    = 3'd2;
   localparam logic [2:0] ST_LOAD   = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [LVL_W-1:0]       level_ff, level_in;
   logic [INDEX_WIDTH-1:0] top_node_ff, top_node_in;
   logic [NC_W-1:0]        top_nc_ff, top_nc_in;
   logic                   top_emit_ff, top_emit_in;
   logic [kitw_pkg::FIELD_WIDTH-1:0] res_node_ff, res_node_in;
   logic                   res_exh_ff, res_exh_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   kitw_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic [INDEX_WIDTH-1:0] node_count_ff, node_count_in;
   logic [FAN_W-1:0]       fanout_ff, fanout_in;

   logic [FAN_W-1:0]       eff_k;
   logic [NC_W-1:0]        half;
   logic [NC_W-1:0]        limit;
   logic                   emit_now;
   logic                   group_done;
   logic                   csr_wr;

   logic                   child_go;
   logic [INDEX_WIDTH-1:0] child_index;
   logic                   child_exists;

   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_waddr;
   logic [FRAME_W-1:0]     ram_wdata;
   logic                   ram_re;
   logic [ADDR_W-1:0]      ram_raddr;
   logic [FRAME_W-1:0]     ram_rdata;
   logic [LVL_W-1:0]       level_m1;
   logic [LVL_W-1:0]       level_m2;

   // ---------------------------------------------------------------- CSRs
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      node_count_in = node_count_ff;
      fanout_in     = fanout_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            kitw_pkg::REG_NODE_COUNT: node_count_in = pwdata[INDEX_WIDTH-1:0];
            kitw_pkg::REG_FANOUT:     fanout_in     = pwdata[FAN_W-1:0];
            default:                  node_count_in = node_count_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         kitw_pkg::REG_NODE_COUNT: prdata = kitw_pkg::CSR_DATA_WIDTH'(node_count_ff);
         kitw_pkg::REG_FANOUT:     prdata = kitw_pkg::CSR_DATA_WIDTH'(fanout_ff);
         default:                  prdata = '0;
      endcase
   end

   // Clamp fanout of 0 or 1 up to 2 so the depth stays bounded.
   assign eff_k = (fanout_ff < kitw_pkg::MIN_FANOUT) ? kitw_pkg::MIN_FANOUT : fanout_ff;
   assign half  = kitw_pkg::half_of(eff_k);

   // ------------------------------------------------------ top-frame decode
   // Emit the node once its before-group is walked; otherwise pick the
   // group bound and close the frame when the child number runs past it.
   assign emit_now   = (top_nc_ff > half) && !top_emit_ff;
   assign limit      = (top_nc_ff <= half) ? half : NC_W'(eff_k);
   assign group_done = top_nc_ff > limit;

   assign level_m1  = level_ff - LVL_W'(1);
   assign level_m2  = level_ff - LVL_W'(2);
   assign ram_waddr = level_m1[ADDR_W-1:0];
   assign ram_raddr = level_m2[ADDR_W-1:0];

   // --------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      top_node_in  = top_node_ff;
      top_nc_in    = top_nc_ff;
      top_emit_in  = top_emit_ff;
      res_node_in  = res_node_ff;
      res_exh_in   = res_exh_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      child_go     = 1'b0;
      ram_we       = 1'b0;
      ram_wdata    = {top_node_ff, top_nc_ff + NC_W'(1), top_emit_ff};
      ram_re       = 1'b0;

      // Drop the response once the consumer takes it.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.action == kitw_pkg::ACTION_START) begin
                  // Discard any walk in progress and open the root frame.
                  level_in    = LVL_W'(1);
                  top_node_in = req_data.root_index[INDEX_WIDTH-1:0];
                  top_nc_in   = NC_W'(1);
                  top_emit_in = 1'b0;
               end else begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            if (level_ff == '0) begin
               res_node_in = '0;
               res_exh_in  = 1'b1;
               state_in    = ST_RESULT;
            end else if (emit_now) begin
               top_emit_in = 1'b1;
               res_node_in = kitw_pkg::FIELD_WIDTH'(top_node_ff);
               res_exh_in  = 1'b0;
               state_in    = ST_RESULT;
            end else if (group_done) begin
               // Pop; refill the top frame from the RAM if one remains.
               level_in = level_m1;
               if (level_ff >= LVL_W'(2)) begin
                  ram_re   = 1'b1;
                  state_in = ST_LOAD;
               end
            end else begin
               child_go = 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_EVAL;
            if (child_exists) begin
               top_nc_in = top_nc_ff + NC_W'(1);
               // Push only while a frame is free; else skip the subtree.
               if (level_ff < LVL_W'(STACK_DEPTH)) begin
                  ram_we      = 1'b1;
                  top_node_in = child_index;
                  top_nc_in   = NC_W'(1);
                  top_emit_in = 1'b0;
                  level_in    = level_ff + LVL_W'(1);
               end
            end else begin
               // Later children are missing too: skip the rest of the group.
               top_nc_in = limit + NC_W'(1);
            end
         end
         ST_LOAD: begin
            {top_node_in, top_nc_in, top_emit_in} = ram_rdata;
            state_in = ST_EVAL;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.node_index = res_node_ff;
               rsp_data_in.exhausted  = res_exh_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         level_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= INDEX_WIDTH'(1);
         fanout_ff     <= kitw_pkg::FANOUT_RESET;
      end else begin
         state_ff      <= state_in;
         level_ff      <= level_in;
         rsp_valid_ff  <= rsp_valid_in;
         node_count_ff <= node_count_in;
         fanout_ff     <= fanout_in;
      end
   end

   always_ff @(posedge clock) begin
      top_node_ff <= top_node_in;
      top_nc_ff   <= top_nc_in;
      top_emit_ff <= top_emit_in;
      res_node_ff <= res_node_in;
      res_exh_ff  <= res_exh_in;
      rsp_data_ff <= rsp_data_in;
   end

   // -------------------------------------------------------- submodules
   kitw_child_unit #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_child (
      .clock        (clock),
      .go           (child_go),
      .node         (top_node_ff),
      .fanout       (eff_k),
      .child_num    (top_nc_ff),
      .node_count   (node_count_ff),
      .child_index  (child_index),
      .child_exists (child_exists)
   );

   kitw_frame_ram #(
      .DEPTH       (STACK_DEPTH),
      .FRAME_WIDTH (FRAME_W)
   ) u_frames (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // -------------------------------------------------------- assertions
   `KITW_ASSERT_NORST(a_reset_clears, clock, reset |=> (state_ff == ST_IDLE && level_ff == '0 && !rsp_valid_ff))
   `KITW_ASSERT(a_level_bounded, clock, reset, level_ff <= LVL_W'(STACK_DEPTH))
   `KITW_ASSERT(a_start_opens_root, clock, reset, (req_valid && req_ready && req_data.action == kitw_pkg::ACTION_START) |=> (level_ff == LVL_W'(1) && state_ff == ST_IDLE))
   `KITW_ASSERT(a_exhausted_empty, clock, reset, (state_ff == ST_RESULT && res_exh_ff) |-> (level_ff == '0))
   `KITW_ASSERT(a_load_after_pop, clock, reset, (state_ff == ST_LOAD) |-> ($past(state_ff) == ST_EVAL && level_ff != '0))

endmodule

`default_nettype wire

[rtl/core/kitw_child_unit.sv]
// Shared child-index unit: registered node*fanout product, then add and bound check.
// Depends on kitw_pkg.
`default_nettype none

module kitw_child_unit #(
   parameter int INDEX_WIDTH = kitw_pkg::INDEX_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              go,
   input  wire logic [INDEX_WIDTH-1:0]            node,
   input  wire logic [kitw_pkg::FANOUT_WIDTH-1:0] fanout,
   input  wire logic [kitw_pkg::NC_WIDTH-1:0]     child_num,
   input  wire logic [INDEX_WIDTH-1:0]            node_count,
   output logic      [INDEX_WIDTH-1:0]            child_index,
   output logic                                   child_exists
);

   localparam int PROD_W = INDEX_WIDTH + kitw_pkg::FANOUT_WIDTH;
   localparam int SUM_W  = PROD_W + 1;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [SUM_W-1:0]  child_sum;

   assign prod_in = PROD_W'(node) * PROD_W'(fanout);

   // Hold the product for the compare cycle.
   always_ff @(posedge clock) begin
      if (go) begin
         prod_ff <= prod_in;
      end
   end

   assign child_sum    = {1'b0, prod_ff} + SUM_W'(child_num);
   assign child_exists = child_sum < SUM_W'(node_count);
   assign child_index  = child_sum[INDEX_WIDTH-1:0];

endmodule

`default_nettype wire

[rtl/core/kitw_frame_ram.sv]
// Frame stack storage for the walker: one write port, one registered read port.
// Depends on kitw_pkg for the default depth and frame width.
`default_nettype none

module kitw_frame_ram #(
   parameter int DEPTH       = kitw_pkg::STACK_DEPTH_DEF,
   parameter int FRAME_WIDTH = kitw_pkg::INDEX_WIDTH_DEF + kitw_pkg::NC_WIDTH + 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [FRAME_WIDTH-1:0]   wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [FRAME_WIDTH-1:0]   rd_data
);

   logic [FRAME_WIDTH-1:0] mem [DEPTH];
   logic [FRAME_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the k-ary heap tree in-order walker unit.
// Runs a directed table, then random start/next walks under random backpressure.
// Needs kitw_pkg and the kary_tree_inorder_walker_unit RTL.

module tb_top;

   localparam int SETTLE_CYCLES   = 100;
   localparam int STALL_LIMIT     = 4000;
   localparam int HOLD_CYCLES     = 400;
   localparam int RANDOM_PHASES   = 12;
   localparam int BEATS_PER_PHASE = 100;
   localparam int IDLE_PCT        = 27;
   localparam int QUIET_PHASE     = 5;
   localparam int HOLD_PHASE      = 2;
   localparam int AW              = kitw_pkg::CSR_ADDR_WIDTH;
   localparam int DW              = kitw_pkg::CSR_DATA_WIDTH;
   localparam int NCW             = kitw_pkg::NC_WIDTH;
   localparam int SD              = kitw_pkg::STACK_DEPTH_DEF;

   localparam logic [AW-1:0] ADDR_NODE_COUNT = {kitw_pkg::REG_NODE_COUNT, 2'b00};
   localparam logic [AW-1:0] ADDR_FANOUT     = {kitw_pkg::REG_FANOUT, 2'b00};

   typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      logic [AW-1:0]       addr;
      logic [DW-1:0]       wdata;
      kitw_pkg::req_type   beat;
      bit                  typed;
      kitw_pkg::rsp_type   want;
   } plan_row_type;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   kitw_pkg::req_type   req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   kitw_pkg::rsp_type   rsp_data;
   logic                psel      = 1'b0;
   logic                penable   = 1'b0;
   logic                pwrite    = 1'b0;
   logic [AW-1:0]       paddr     = '0;
   logic [DW-1:0]       pwdata    = '0;
   logic [DW-1:0]       prdata;
   logic                pready;

   int  idle_pct     = IDLE_PCT;
   bit  hold_request = 1'b0;
   int  fail_count   = 0;
   int  quiet_cycles = 0;

   kitw_pkg::rsp_type expected_visits [$];
   kitw_pkg::rsp_type visit_want;
   plan_row_type      plan [$];

   // Shadow of the walker: configuration and the open-frame stack.
   logic [31:0]     cfg_node_count = 32'd1;
   logic [15:0]     cfg_fanout     = kitw_pkg::FANOUT_RESET;
   logic [31:0]     walk_node       [SD];
   logic [NCW-1:0]  walk_next_child [SD];
   bit              walk_emitted    [SD];
   int              walk_level = 0;

   always #5 clock = ~clock;

   kary_tree_inorder_walker_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Open a frame for a node; a full stack drops the node with its subtree.
   function automatic void open_frame(input logic [31:0] node);
      if (walk_level < SD) begin
         walk_node[walk_level]       = node;
         walk_next_child[walk_level] = NCW'(1);
         walk_emitted[walk_level]    = 1'b0;
         walk_level++;
      end
   endfunction

   // Advance the shadow walk by one beat; return 1 when the beat yields a visit.
   function automatic bit predict_visit(input kitw_pkg::req_type beat,
                                        output kitw_pkg::rsp_type visit);
      logic [NCW-1:0] k;
      logic [NCW-1:0] half;
      logic [NCW-1:0] nc;
      logic [NCW-1:0] lim;
      logic [63:0]    child;
      int             top;
      visit = '0;
      // Fanout of zero or one walks as a binary tree.
      k    = (cfg_fanout < kitw_pkg::MIN_FANOUT) ? NCW'(kitw_pkg::MIN_FANOUT)
                                                 : NCW'(cfg_fanout);
      half = (k + NCW'(1)) >> 1;
      if (beat.action == kitw_pkg::ACTION_START) begin
         // A start in the middle of a walk discards it.
         walk_level = 0;
         open_frame(beat.root_index);
         return 1'b0;
      end
      while (walk_level > 0) begin
         top = walk_level - 1;
         nc  = walk_next_child[top];
         if (nc > half && !walk_emitted[top]) begin
            walk_emitted[top] = 1'b1;
            visit.node_index  = walk_node[top];
            visit.exhausted   = 1'b0;
            return 1'b1;
         end
         lim = (nc <= half) ? half : k;
         if (nc > lim) begin
            walk_level--;
            continue;
         end
         // Form the child at full width so it cannot wrap past node_count.
         child = 64'(walk_node[top]) * 64'(k) + 64'(nc);
         if (child < 64'(cfg_node_count)) begin
            walk_next_child[top] = nc + NCW'(1);
            open_frame(child[31:0]);
         end else begin
            // Missing child: the rest of this group is missing as well.
            walk_next_child[top] = lim + NCW'(1);
         end
      end
      visit.node_index = '0;
      visit.exhausted  = 1'b1;
      return 1'b1;
   endfunction

   // Offer one beat from a falling edge; return at the falling edge after acceptance.
   // Leave valid high so a following beat needs no second assignment in one step.
   task automatic send_beat(input kitw_pkg::req_type beat, input bit typed,
                            input kitw_pkg::rsp_type want);
      kitw_pkg::rsp_type visit;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (predict_visit(beat, visit))
         expected_visits.insert(expected_visits.size(), typed ? want : visit);
      @(negedge clock);
   endtask

   // Drop valid, wait for every visit, then let a trailing start settle.
   task automatic drain_walker();
      req_valid <= 1'b0;
      while (expected_visits.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Setup then access cycle; the register lands at the access-phase rising edge.
   task automatic write_reg(input logic [AW-1:0] addr, input logic [DW-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == ADDR_NODE_COUNT)
         cfg_node_count = data;
      else
         cfg_fanout = data[15:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic plan_write(input logic [AW-1:0] addr, input logic [DW-1:0] data);
      plan_row_type row;
      row = '{kind: ROW_WRITE, addr: addr, wdata: data, beat: '0, typed: 1'b0,
              want: '0};
      plan.insert(plan.size(), row);
   endtask

   task automatic plan_beat(input logic action, input logic [31:0] root, input bit typed,
                            input logic [31:0] node, input logic exh);
      plan_row_type row;
      row = '{kind: ROW_BEAT, addr: '0, wdata: '0,
              beat: '{action: action, root_index: root}, typed: typed,
              want: '{node_index: node, exhausted: exh}};
      plan.insert(plan.size(), row);
   endtask

   // Pick a subtree root: mostly inside the tree, sometimes anywhere in 32 bits.
   function automatic logic [31:0] pick_root();
      logic [31:0] bound;
      bound = (cfg_node_count < 32'd1000) ? cfg_node_count + 32'd1 : 32'd1000;
      if ($urandom_range(99) < 70)
         return $urandom_range(0, bound);
      return $urandom();
   endfunction

   // Score every response beat against the oldest expected visit.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_visits.size() == 0) begin
            fail_count++;
            $display("%0t: response with nothing expected: expected none, got node %h exh %b",
                     $time, rsp_data.node_index, rsp_data.exhausted);
         end else begin
            visit_want = expected_visits.pop_front();
            if (rsp_data.node_index !== visit_want.node_index) begin
               fail_count++;
               $display("%0t: node_index mismatch: expected %h, got %h",
                        $time, visit_want.node_index, rsp_data.node_index);
            end
            if (rsp_data.exhausted !== visit_want.exhausted) begin
               fail_count++;
               $display("%0t: exhausted mismatch: expected %b, got %b",
                        $time, visit_want.exhausted, rsp_data.exhausted);
            end
         end
      end
   end

   // Watchdog: end the run once no beat has moved on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT - 1) begin
         $display("%0t: timeout, no beat accepted for %0d cycles", $time, STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: random ready, plus one long hold-off on request so the
   // walker backs up and drops req_ready while the sender keeps offering.
   initial begin
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   initial begin
      int          sent;
      int          run_len;
      logic [31:0] nc_pick;
      logic [15:0] fo_pick;

      // Directed table. Reset leaves node_count 1, fanout 2.
      // Next before any start, repeated: exhausted every time.
      plan_beat(kitw_pkg::ACTION_NEXT,  32'h0000_0000, 1'b1, 32'h0, 1'b1);
      plan_beat(kitw_pkg::ACTION_NEXT,  32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1);
      // Lone root, then the walk runs dry.
      plan_beat(kitw_pkg::ACTION_START, 32'h0000_0000, 1'b0, 32'h0, 1'b0);
      plan_beat(kitw_pkg::ACTION_NEXT,  32'h0000_0000, 1'b1, 32'h0, 1'b0);
      plan_beat(kitw_pkg::ACTION_NEXT,  32'h0000_0000, 1'b1, 32'h0, 1'b1);
      // Root beyond node_count is still produced once.
      plan_beat(kitw_pkg::ACTION_START, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0);
      plan_beat(kitw_pkg::ACTION_NEXT,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0);
      plan_beat(kitw_pkg::ACTION_NEXT,  32'h0000_0000, 1'b1, 32'h0, 1'b1);
      // Seven-node binary tree, restarted in the middle of the walk.
      plan_write(ADDR_NODE_COUNT, 32'd7);
      plan_write(ADDR_FANOUT, 32'd2);
      plan_beat(kitw_pkg::ACTION_START, 32'd0, 1'b0, 32'h0, 1'b0);
      repeat (3) plan_beat(kitw_pkg::ACTION_NEXT, 32'd0, 1'b0, 32'h0, 1'b0);
      plan_beat(kitw_pkg::ACTION_START, 32'd2, 1'b0, 32'h0, 1'b0);
      repeat (3) plan_beat(kitw_pkg::ACTION_NEXT, 32'd0, 1'b0, 32'h0, 1'b0);
      plan_beat(kitw_pkg::ACTION_NEXT, 32'd0, 1'b1, 32'h0, 1'b1);
      // Fanout zero walks as binary; full-size tree bottoms out at 2^31-1.
      plan_write(ADDR_NODE_COUNT, 32'hFFFF_FFFF);
      plan_write(ADDR_FANOUT, 32'd0);
      plan_beat(kitw_pkg::ACTION_START, 32'd0, 1'b0, 32'h0, 1'b0);
      plan_beat(kitw_pkg::ACTION_NEXT, 32'd0, 1'b1, 32'h7FFF_FFFF, 1'b0);
      plan_beat(kitw_pkg::ACTION_NEXT, 32'd0, 1'b0, 32'h0, 1'b0);
      // Widest fanout: the great-grandchild's children would wrap 32 bits.
      plan_write(ADDR_FANOUT, 32'h0000_FFFF);
      plan_beat(kitw_pkg::ACTION_START, 32'd0, 1'b0, 32'h0, 1'b0);
      plan_beat(kitw_pkg::ACTION_NEXT, 32'd0, 1'b1, 32'hFFFF_0001, 1'b0);
      plan_beat(kitw_pkg::ACTION_NEXT, 32'd0, 1'b0, 32'h0, 1'b0);
      // Fanout one and an empty tree: only the root comes out.
      plan_write(ADDR_FANOUT, 32'd1);
      plan_write(ADDR_NODE_COUNT, 32'd0);
      plan_beat(kitw_pkg::ACTION_START, 32'd5, 1'b0, 32'h0, 1'b0);
      plan_beat(kitw_pkg::ACTION_NEXT, 32'd0, 1'b1, 32'd5, 1'b0);
      plan_beat(kitw_pkg::ACTION_NEXT, 32'd0, 1'b1, 32'h0, 1'b1);

      // Hold reset, then release it on a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            drain_walker();
            write_reg(plan[i].addr, plan[i].wdata);
         end else begin
            send_beat(plan[i].beat, plan[i].typed, plan[i].want);
         end
      end

      // Random phases: new configuration each, then start/next runs with noise.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_walker();
         case ($urandom_range(3))
            0: begin
               nc_pick = $urandom_range(0, 300);
               fo_pick = 16'($urandom_range(0, 6));
            end
            1: begin
               nc_pick = $urandom();
               fo_pick = 16'($urandom_range(0, 65535));
            end
            2: begin
               nc_pick = 32'hFFFF_FFFF;
               fo_pick = $urandom_range(1) ? 16'd2 : 16'hFFFF;
            end
            default: begin
               nc_pick = $urandom_range(0, 40);
               fo_pick = 16'($urandom_range(2, 65535));
            end
         endcase
         write_reg(ADDR_NODE_COUNT, nc_pick);
         write_reg(ADDR_FANOUT, {16'($urandom_range(65535)), fo_pick});
         idle_pct = (phase == QUIET_PHASE) ? 0 : IDLE_PCT;
         if (phase == HOLD_PHASE)
            hold_request = 1'b1;
         sent = 0;
         while (sent < BEATS_PER_PHASE) begin
            if ($urandom_range(99) < 10) begin
               // Stray next: often lands past the end of a walk.
               send_beat('{action: kitw_pkg::ACTION_NEXT, root_index: $urandom()}, 1'b0, '0);
               sent++;
            end else begin
               send_beat('{action: kitw_pkg::ACTION_START, root_index: pick_root()},
                         1'b0, '0);
               run_len = $urandom_range(1, 25);
               repeat (run_len)
                  send_beat('{action: kitw_pkg::ACTION_NEXT, root_index: $urandom()},
                            1'b0, '0);
               sent += 1 + run_len;
            end
         end
      end

      drain_walker();
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
